@@ hw/rtl/i2cmbe_pkg.sv @@
`default_nettype none

package i2cmbe_pkg;

    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int DELAY_W   = 10;
    localparam int BITCNT_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE      = 4'd8;
    localparam logic [CFG_W-1:0]    TICKS_PER_UNIT_RST = 8'd1;
    localparam logic [CFG_W-1:0]    ACK_TIMEOUT_RST    = 8'd250;

    // Command codes carried in the kind field.
    localparam logic [KIND_W-1:0] K_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] K_START = 3'd1;
    localparam logic [KIND_W-1:0] K_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] K_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] K_READ  = 3'd4;
    localparam logic [KIND_W-1:0] K_WAIT  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 1'd1;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_SP_A    = 5'd3,
        PH_SP_B    = 5'd4,
        PH_SP_C    = 5'd5,
        PH_WR_LOW  = 5'd6,
        PH_WR_HIGH = 5'd7,
        PH_WR_TAIL = 5'd8,
        PH_RD_LOW  = 5'd9,
        PH_RD_HIGH = 5'd10,
        PH_AK_LOW  = 5'd11,
        PH_AK_HIGH = 5'd12,
        PH_WA_A    = 5'd13,
        PH_WA_B    = 5'd14,
        PH_WA_POLL = 5'd15
    } t_phase;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_oe;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_error;
        logic              cmd_rejected;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/i2cmbe_cmd_if.sv @@
`default_nettype none

interface i2cmbe_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [i2cmbe_pkg::KIND_W-1:0]     kind;
    logic [i2cmbe_pkg::BYTE_W-1:0]     tx_byte;
    logic                              send_ack;
    logic                              sda_in;

    modport source (output valid, kind, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, kind, tx_byte, send_ack, sda_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2cmbe_res_if.sv @@
`default_nettype none

interface i2cmbe_res_if;
    logic                          valid;
    logic                          ready;
    logic                          scl;
    logic                          sda_out;
    logic                          sda_oe;
    logic                          busy_res;
    logic                          done_res;
    logic [i2cmbe_pkg::BYTE_W-1:0] rx_byte;
    logic                          ack_error;
    logic                          cmd_rejected;

    modport source (output valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte,
                    ack_error, cmd_rejected, input ready);
    modport sink   (input valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte,
                    ack_error, cmd_rejected, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2cmbe_seq.sv @@
`default_nettype none

module i2cmbe_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire i2cmbe_pkg::t_cfg_wr           i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [i2cmbe_pkg::KIND_W-1:0] i_kind,
    input  wire logic [i2cmbe_pkg::BYTE_W-1:0] i_tx_byte,
    input  wire logic                          i_send_ack,
    input  wire logic                          i_sda_in,
    output      i2cmbe_pkg::t_result           o_res
);

    localparam int DW = i2cmbe_pkg::DELAY_W;
    localparam int BW = i2cmbe_pkg::BYTE_W;
    localparam int CW = i2cmbe_pkg::BITCNT_W;

    logic [i2cmbe_pkg::CFG_W-1:0] r_ticks_per_unit;
    logic [i2cmbe_pkg::CFG_W-1:0] r_ack_timeout;

    i2cmbe_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0] r_bit_count, n_bit_count;
    logic [BW-1:0] r_shift, n_shift;
    logic [DW-1:0] r_delay, n_delay;
    logic [BW-1:0] r_poll, n_poll;
    logic          r_ack_choice, n_ack_choice;
    logic [BW-1:0] r_rx_hold, n_rx_hold;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;
    logic          r_oe, n_oe;
    logic          r_err, n_err;

    logic               w_done;
    logic               w_rej;
    logic               w_is_cmd;
    logic               w_enter;
    i2cmbe_pkg::t_phase w_target;
    logic [DW-1:0]      w_u1, w_u2, w_u4;
    logic [DW-1:0]      w_dly_dec;
    logic [CW-1:0]      w_bit_inc;
    logic [BW-1:0]      w_rd_shift;

    // A unit setting of zero behaves as one tick.
    assign w_u1 = (r_ticks_per_unit == '0) ? DW'(1) : DW'(r_ticks_per_unit);
    assign w_u2 = w_u1 << 1;
    assign w_u4 = w_u1 << 2;
    assign w_dly_dec  = (r_delay != '0) ? r_delay - DW'(1) : '0;
    assign w_bit_inc  = r_bit_count + CW'(1);
    assign w_rd_shift = {r_shift[BW-2:0], i_sda_in};

    always_comb begin
        case (i_kind) inside
            i2cmbe_pkg::K_START, i2cmbe_pkg::K_STOP, i2cmbe_pkg::K_WRITE,
            i2cmbe_pkg::K_READ, i2cmbe_pkg::K_WAIT: w_is_cmd = 1'b1;
            default:                                w_is_cmd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= i2cmbe_pkg::TICKS_PER_UNIT_RST;
            r_ack_timeout    <= i2cmbe_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                i2cmbe_pkg::CFG_TICKS_PER_UNIT: r_ticks_per_unit <= i_cfg.data;
                i2cmbe_pkg::CFG_ACK_TIMEOUT:    r_ack_timeout    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cmbe_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_rx_hold    <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_oe         <= 1'b1;
            r_err        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_rx_hold    <= n_rx_hold;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_oe         <= n_oe;
            r_err        <= n_err;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_rx_hold    = r_rx_hold;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_oe         = r_oe;
        n_err        = r_err;
        w_done       = 1'b0;
        w_rej        = 1'b0;
        w_enter      = 1'b0;
        w_target     = i2cmbe_pkg::PH_IDLE;

        if (r_phase == i2cmbe_pkg::PH_IDLE) begin
            unique case (i_kind)
                i2cmbe_pkg::K_START: begin
                    w_enter  = 1'b1;
                    w_target = i2cmbe_pkg::PH_ST_A;
                end
                i2cmbe_pkg::K_STOP: begin
                    w_enter  = 1'b1;
                    w_target = i2cmbe_pkg::PH_SP_A;
                end
                i2cmbe_pkg::K_WRITE: begin
                    n_shift     = i_tx_byte;
                    n_bit_count = '0;
                    w_enter     = 1'b1;
                    w_target    = i2cmbe_pkg::PH_WR_LOW;
                end
                i2cmbe_pkg::K_READ: begin
                    n_shift      = '0;
                    n_bit_count  = '0;
                    n_ack_choice = i_send_ack;
                    w_enter      = 1'b1;
                    w_target     = i2cmbe_pkg::PH_RD_LOW;
                end
                i2cmbe_pkg::K_WAIT: begin
                    n_err    = 1'b0;
                    w_enter  = 1'b1;
                    w_target = i2cmbe_pkg::PH_WA_A;
                end
                default: ;
            endcase
        end else begin
            w_rej = w_is_cmd;
            if (r_phase == i2cmbe_pkg::PH_WA_POLL) begin
                if (!i_sda_in) begin
                    n_scl   = 1'b0;
                    n_phase = i2cmbe_pkg::PH_IDLE;
                    n_delay = '0;
                    w_done  = 1'b1;
                end else if (r_poll >= r_ack_timeout) begin
                    n_err    = 1'b1;
                    w_enter  = 1'b1;
                    w_target = i2cmbe_pkg::PH_SP_A;
                end else begin
                    n_poll = r_poll + BW'(1);
                end
            end else begin
                n_delay = w_dly_dec;
                if (w_dly_dec == '0) begin
                    unique case (r_phase)
                        i2cmbe_pkg::PH_ST_A: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_ST_B;
                        end
                        i2cmbe_pkg::PH_ST_B, i2cmbe_pkg::PH_AK_HIGH: begin
                            n_scl   = 1'b0;
                            n_phase = i2cmbe_pkg::PH_IDLE;
                            w_done  = 1'b1;
                        end
                        i2cmbe_pkg::PH_SP_A: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_SP_B;
                        end
                        i2cmbe_pkg::PH_SP_B: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_SP_C;
                        end
                        i2cmbe_pkg::PH_SP_C: begin
                            n_phase = i2cmbe_pkg::PH_IDLE;
                            w_done  = 1'b1;
                        end
                        i2cmbe_pkg::PH_WR_LOW: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_WR_HIGH;
                        end
                        i2cmbe_pkg::PH_WR_HIGH: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_WR_TAIL;
                        end
                        i2cmbe_pkg::PH_WR_TAIL: begin
                            n_shift     = {r_shift[BW-2:0], 1'b0};
                            n_bit_count = w_bit_inc;
                            if (w_bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
                                n_phase = i2cmbe_pkg::PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                w_enter  = 1'b1;
                                w_target = i2cmbe_pkg::PH_WR_LOW;
                            end
                        end
                        i2cmbe_pkg::PH_RD_LOW: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_RD_HIGH;
                        end
                        i2cmbe_pkg::PH_RD_HIGH: begin
                            n_shift     = w_rd_shift;
                            n_bit_count = w_bit_inc;
                            w_enter     = 1'b1;
                            if (w_bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
                                n_rx_hold = w_rd_shift;
                                w_target  = i2cmbe_pkg::PH_AK_LOW;
                            end else begin
                                w_target  = i2cmbe_pkg::PH_RD_LOW;
                            end
                        end
                        i2cmbe_pkg::PH_AK_LOW: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_AK_HIGH;
                        end
                        i2cmbe_pkg::PH_WA_A: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_WA_B;
                        end
                        i2cmbe_pkg::PH_WA_B: begin
                            w_enter  = 1'b1;
                            w_target = i2cmbe_pkg::PH_WA_POLL;
                        end
                        default: begin
                            n_phase = i2cmbe_pkg::PH_IDLE;
                            n_delay = '0;
                        end
                    endcase
                end
            end
        end

        // Entry actions of the phase being entered; the write bit and the
        // acknowledge level come from the already updated shift and choice.
        if (w_enter) begin
            n_phase = w_target;
            unique case (w_target)
                i2cmbe_pkg::PH_ST_A: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_oe = 1'b1; n_delay = w_u4;
                end
                i2cmbe_pkg::PH_ST_B: begin
                    n_sda = 1'b0; n_delay = w_u4;
                end
                i2cmbe_pkg::PH_SP_A: begin
                    n_scl = 1'b0; n_sda = 1'b0; n_oe = 1'b1; n_delay = w_u4;
                end
                i2cmbe_pkg::PH_SP_B: begin
                    n_scl = 1'b1; n_delay = DW'(1);
                end
                i2cmbe_pkg::PH_SP_C: begin
                    n_sda = 1'b1; n_delay = w_u4;
                end
                i2cmbe_pkg::PH_WR_LOW: begin
                    n_scl = 1'b0; n_oe = 1'b1; n_sda = n_shift[BW-1]; n_delay = w_u2;
                end
                i2cmbe_pkg::PH_WR_HIGH, i2cmbe_pkg::PH_AK_HIGH: begin
                    n_scl = 1'b1; n_delay = w_u2;
                end
                i2cmbe_pkg::PH_WR_TAIL: begin
                    n_scl = 1'b0; n_delay = w_u2;
                end
                i2cmbe_pkg::PH_RD_LOW: begin
                    n_scl = 1'b0; n_oe = 1'b0; n_sda = 1'b1; n_delay = w_u2;
                end
                i2cmbe_pkg::PH_RD_HIGH, i2cmbe_pkg::PH_WA_B: begin
                    n_scl = 1'b1; n_delay = w_u1;
                end
                i2cmbe_pkg::PH_AK_LOW: begin
                    n_scl = 1'b0; n_oe = 1'b1; n_sda = !n_ack_choice; n_delay = w_u2;
                end
                i2cmbe_pkg::PH_WA_A: begin
                    n_oe = 1'b0; n_sda = 1'b1; n_delay = w_u1;
                end
                i2cmbe_pkg::PH_WA_POLL: begin
                    n_poll = '0; n_delay = '0;
                end
                default: begin
                    n_phase = i2cmbe_pkg::PH_IDLE;
                    n_delay = '0;
                end
            endcase
        end else if (w_done) begin
            n_delay = '0;
        end
    end

    always_comb begin
        o_res.scl          = n_scl;
        o_res.sda_out      = n_sda;
        o_res.sda_oe       = n_oe;
        o_res.busy_res     = (n_phase != i2cmbe_pkg::PH_IDLE);
        o_res.done_res     = w_done;
        o_res.rx_byte      = n_rx_hold;
        o_res.ack_error    = n_err;
        o_res.cmd_rejected = w_rej;
    end

    // Every timed phase holds a nonzero count; reaching zero moves on at once.
    a_timed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != i2cmbe_pkg::PH_IDLE && r_phase != i2cmbe_pkg::PH_WA_POLL)
        |-> (r_delay != '0))
        else $error("timed phase with empty delay count");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cmbe_pkg::PH_IDLE) |-> (r_delay == '0))
        else $error("idle with pending delay count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_done) |=> (r_phase == i2cmbe_pkg::PH_IDLE))
        else $error("sequence reported done but did not return to idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cmbe_pkg::BITS_PER_BYTE)
        else $error("bit count beyond one byte");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_rej) |-> (r_phase != i2cmbe_pkg::PH_IDLE && w_is_cmd))
        else $error("command flagged as rejected while idle");

endmodule

`default_nettype wire

@@ hw/rtl/i2cmbe_res_reg.sv @@
`default_nettype none

module i2cmbe_res_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire i2cmbe_pkg::t_result i_res,
    output      logic                o_room,
    i2cmbe_res_if.source             o_res
);

    logic                r_valid;
    i2cmbe_pkg::t_result r_res;

    // The register can take a new result when empty or when its content
    // leaves in this same cycle.
    assign o_room = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.scl          = r_res.scl;
    assign o_res.sda_out      = r_res.sda_out;
    assign o_res.sda_oe       = r_res.sda_oe;
    assign o_res.busy_res     = r_res.busy_res;
    assign o_res.done_res     = r_res.done_res;
    assign o_res.rx_byte      = r_res.rx_byte;
    assign o_res.ack_error    = r_res.ack_error;
    assign o_res.cmd_rejected = r_res.cmd_rejected;

endmodule

`default_nettype wire

@@ hw/rtl/i2c_master_byte_engine_unit.sv @@
// A result appears in the output register in the cycle after its command transfer.
// Throughput: one tick item per cycle; the single output register frees as it is read.
// A stalled result output blocks new items only while that register stays full.
// Reset: synchronous, active low; sequencer idle, SCL and SDA high and driven,
// one tick per unit, acknowledge timeout 250 (error on 251st high sample), output register empty.
`default_nettype none

module i2c_master_byte_engine_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [i2cmbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [i2cmbe_pkg::CFG_W-1:0]     i_cfg_data,
    i2cmbe_cmd_if.sink                            i_cmd,
    i2cmbe_res_if.source                          o_res
);

    i2cmbe_pkg::t_cfg_wr w_cfg;
    i2cmbe_pkg::t_result w_res;
    logic                w_room;
    logic                w_accept;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign i_cmd.ready = w_room;
    assign w_accept    = i_cmd.valid && w_room;

    i2cmbe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_accept   (w_accept),
        .i_kind     (i_cmd.kind),
        .i_tx_byte  (i_cmd.tx_byte),
        .i_send_ack (i_cmd.send_ack),
        .i_sda_in   (i_cmd.sda_in),
        .o_res      (w_res)
    );

    i2cmbe_res_reg u_res_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ sim/i2c_master_byte_engine_unit_test.sv @@
`timescale 1ns / 100ps

module i2c_master_byte_engine_unit_test;

    typedef logic [i2cmbe_pkg::KIND_W-1:0] t_kind;
    typedef logic [i2cmbe_pkg::BYTE_W-1:0] t_byte;

    localparam t_kind KIND_SPARE_A = 3'd6;
    localparam t_kind KIND_SPARE_B = 3'd7;
    localparam int NEVER_ACK     = 256;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int BATCH_ITEMS   = 110;

    typedef struct {
        i2cmbe_pkg::t_phase              phase;
        logic [i2cmbe_pkg::BITCNT_W-1:0] bit_count;
        t_byte                           shift;
        int unsigned                     delay;
        t_byte                           polls;
        logic                            ack_choice;
        t_byte                           rx_hold;
        logic                            scl;
        logic                            sda;
        logic                            oe;
        logic                            err;
        logic                            done;
        logic                            rejected;
    } t_bus_state;

    typedef struct {
        t_kind kind;
        t_byte tx_byte;
        logic  send_ack;
        logic  sda_in;
        bit    drain;
    } t_tick_item;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [i2cmbe_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [i2cmbe_pkg::CFG_W-1:0]        i_cfg_data;

    i2cmbe_cmd_if cmd_bus ();
    i2cmbe_res_if res_bus ();

    i2c_master_byte_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    // Register copies shared by the stimulus planner and the checker; they only
    // change while nothing is in flight.
    logic [i2cmbe_pkg::CFG_W-1:0] unit_ticks = i2cmbe_pkg::TICKS_PER_UNIT_RST;
    logic [i2cmbe_pkg::CFG_W-1:0] ack_limit  = i2cmbe_pkg::ACK_TIMEOUT_RST;

    t_bus_state            plan_bus;
    t_bus_state            model_bus;
    t_tick_item            cmd_queue[$];
    i2cmbe_pkg::t_result   expected_pins[$];
    t_tick_item            item;
    int unsigned planned_items = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count;
    int unsigned idle_pct      = 30;
    int unsigned send_wait     = 0;
    int unsigned recv_wait     = 0;
    bit          drain_next    = 1'b0;
    bit          hold_req      = 1'b0;
    logic        cmd_taken     = 1'b0;
    logic        res_taken     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 99) < idle_pct) begin
            return $urandom_range(0, 18);
        end
        return 0;
    endfunction

    function automatic t_bus_state bus_at_reset();
        t_bus_state s;
        s.phase      = i2cmbe_pkg::PH_IDLE;
        s.bit_count  = '0;
        s.shift      = '0;
        s.delay      = 0;
        s.polls      = '0;
        s.ack_choice = 1'b0;
        s.rx_hold    = '0;
        s.scl        = 1'b1;
        s.sda        = 1'b1;
        s.oe         = 1'b1;
        s.err        = 1'b0;
        s.done       = 1'b0;
        s.rejected   = 1'b0;
        return s;
    endfunction

    // A unit register of zero behaves as one tick per unit.
    function automatic int unsigned unit_span(int unsigned n);
        return n * ((unit_ticks == '0) ? 1 : unit_ticks);
    endfunction

    function automatic t_bus_state end_sequence(t_bus_state s);
        s.phase = i2cmbe_pkg::PH_IDLE;
        s.delay = 0;
        s.done  = 1'b1;
        return s;
    endfunction

    function automatic t_bus_state enter_phase(t_bus_state s, i2cmbe_pkg::t_phase p);
        s.phase = p;
        case (p)
            i2cmbe_pkg::PH_ST_A: begin
                s.scl = 1'b1; s.sda = 1'b1; s.oe = 1'b1; s.delay = unit_span(4);
            end
            i2cmbe_pkg::PH_ST_B: begin
                s.sda = 1'b0; s.delay = unit_span(4);
            end
            i2cmbe_pkg::PH_SP_A: begin
                s.scl = 1'b0; s.sda = 1'b0; s.oe = 1'b1; s.delay = unit_span(4);
            end
            i2cmbe_pkg::PH_SP_B: begin
                s.scl = 1'b1; s.delay = 1;
            end
            i2cmbe_pkg::PH_SP_C: begin
                s.sda = 1'b1; s.delay = unit_span(4);
            end
            i2cmbe_pkg::PH_WR_LOW: begin
                s.scl = 1'b0; s.oe = 1'b1; s.sda = s.shift[i2cmbe_pkg::BYTE_W-1];
                s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_WR_HIGH: begin
                s.scl = 1'b1; s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_WR_TAIL: begin
                s.scl = 1'b0; s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_RD_LOW: begin
                s.scl = 1'b0; s.oe = 1'b0; s.sda = 1'b1; s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_RD_HIGH: begin
                s.scl = 1'b1; s.delay = unit_span(1);
            end
            i2cmbe_pkg::PH_AK_LOW: begin
                s.scl = 1'b0; s.oe = 1'b1; s.sda = !s.ack_choice; s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_AK_HIGH: begin
                s.scl = 1'b1; s.delay = unit_span(2);
            end
            i2cmbe_pkg::PH_WA_A: begin
                s.oe = 1'b0; s.sda = 1'b1; s.delay = unit_span(1);
            end
            i2cmbe_pkg::PH_WA_B: begin
                s.scl = 1'b1; s.delay = unit_span(1);
            end
            i2cmbe_pkg::PH_WA_POLL: begin
                s.polls = '0; s.delay = 0;
            end
            default: begin
                s.phase = i2cmbe_pkg::PH_IDLE; s.delay = 0;
            end
        endcase
        return s;
    endfunction

    function automatic t_bus_state advance_phase(t_bus_state s, logic sda);
        case (s.phase)
            i2cmbe_pkg::PH_ST_A:    s = enter_phase(s, i2cmbe_pkg::PH_ST_B);
            i2cmbe_pkg::PH_ST_B: begin
                s.scl = 1'b0;
                s = end_sequence(s);
            end
            i2cmbe_pkg::PH_SP_A:    s = enter_phase(s, i2cmbe_pkg::PH_SP_B);
            i2cmbe_pkg::PH_SP_B:    s = enter_phase(s, i2cmbe_pkg::PH_SP_C);
            i2cmbe_pkg::PH_SP_C:    s = end_sequence(s);
            i2cmbe_pkg::PH_WR_LOW:  s = enter_phase(s, i2cmbe_pkg::PH_WR_HIGH);
            i2cmbe_pkg::PH_WR_HIGH: s = enter_phase(s, i2cmbe_pkg::PH_WR_TAIL);
            i2cmbe_pkg::PH_WR_TAIL: begin
                s.shift     = s.shift << 1;
                s.bit_count = s.bit_count + 1'b1;
                if (s.bit_count >= i2cmbe_pkg::BITS_PER_BYTE) s = end_sequence(s);
                else s = enter_phase(s, i2cmbe_pkg::PH_WR_LOW);
            end
            i2cmbe_pkg::PH_RD_LOW:  s = enter_phase(s, i2cmbe_pkg::PH_RD_HIGH);
            i2cmbe_pkg::PH_RD_HIGH: begin
                s.shift     = {s.shift[i2cmbe_pkg::BYTE_W-2:0], sda};
                s.bit_count = s.bit_count + 1'b1;
                if (s.bit_count >= i2cmbe_pkg::BITS_PER_BYTE) begin
                    s.rx_hold = s.shift;
                    s = enter_phase(s, i2cmbe_pkg::PH_AK_LOW);
                end else begin
                    s = enter_phase(s, i2cmbe_pkg::PH_RD_LOW);
                end
            end
            i2cmbe_pkg::PH_AK_LOW:  s = enter_phase(s, i2cmbe_pkg::PH_AK_HIGH);
            i2cmbe_pkg::PH_AK_HIGH: begin
                s.scl = 1'b0;
                s = end_sequence(s);
            end
            i2cmbe_pkg::PH_WA_A:    s = enter_phase(s, i2cmbe_pkg::PH_WA_B);
            i2cmbe_pkg::PH_WA_B:    s = enter_phase(s, i2cmbe_pkg::PH_WA_POLL);
            default: begin
                s.phase = i2cmbe_pkg::PH_IDLE;
                s.delay = 0;
            end
        endcase
        return s;
    endfunction

    function automatic t_bus_state tick_engine(t_bus_state s, t_kind kind, t_byte tx,
                                               logic sack, logic sda);
        s.done     = 1'b0;
        s.rejected = 1'b0;
        if (s.phase == i2cmbe_pkg::PH_IDLE) begin
            case (kind)
                i2cmbe_pkg::K_START: s = enter_phase(s, i2cmbe_pkg::PH_ST_A);
                i2cmbe_pkg::K_STOP:  s = enter_phase(s, i2cmbe_pkg::PH_SP_A);
                i2cmbe_pkg::K_WRITE: begin
                    s.shift     = tx;
                    s.bit_count = '0;
                    s = enter_phase(s, i2cmbe_pkg::PH_WR_LOW);
                end
                i2cmbe_pkg::K_READ: begin
                    s.shift      = '0;
                    s.bit_count  = '0;
                    s.ack_choice = sack;
                    s = enter_phase(s, i2cmbe_pkg::PH_RD_LOW);
                end
                i2cmbe_pkg::K_WAIT: begin
                    s.err = 1'b0;
                    s = enter_phase(s, i2cmbe_pkg::PH_WA_A);
                end
                default: ;
            endcase
        end else begin
            if (kind >= i2cmbe_pkg::K_START && kind <= i2cmbe_pkg::K_WAIT) s.rejected = 1'b1;
            if (s.phase == i2cmbe_pkg::PH_WA_POLL) begin
                if (!sda) begin
                    s.scl = 1'b0;
                    s = end_sequence(s);
                end else if (s.polls >= ack_limit) begin
                    s.err = 1'b1;
                    s = enter_phase(s, i2cmbe_pkg::PH_SP_A);
                end else begin
                    s.polls = s.polls + 1'b1;
                end
            end else begin
                if (s.delay > 0) s.delay--;
                if (s.delay == 0) s = advance_phase(s, sda);
            end
        end
        return s;
    endfunction

    function automatic i2cmbe_pkg::t_result pin_view(t_bus_state s);
        i2cmbe_pkg::t_result r;
        r.scl          = s.scl;
        r.sda_out      = s.sda;
        r.sda_oe       = s.oe;
        r.busy_res     = (s.phase != i2cmbe_pkg::PH_IDLE);
        r.done_res     = s.done;
        r.rx_byte      = s.rx_hold;
        r.ack_error    = s.err;
        r.cmd_rejected = s.rejected;
        return r;
    endfunction

    function automatic string format_pins(i2cmbe_pkg::t_result r);
        return $sformatf("scl %b sda %b oe %b busy %b done %b rx %02h err %b rej %b",
                         r.scl, r.sda_out, r.sda_oe, r.busy_res, r.done_res, r.rx_byte,
                         r.ack_error, r.cmd_rejected);
    endfunction

    task automatic push_tick(t_kind kind, t_byte tx, logic sack, logic sda);
        t_tick_item t;
        t.kind     = kind;
        t.tx_byte  = tx;
        t.send_ack = sack;
        t.sda_in   = sda;
        t.drain    = drain_next;
        drain_next = 1'b0;
        plan_bus = tick_engine(plan_bus, kind, tx, sack, sda);
        cmd_queue.push_back(t);
        planned_items++;
    endtask

    // Issues one command and keeps ticking until the sequence is over. While the
    // engine is busy some ticks carry commands that must be refused. During the
    // acknowledge poll SDA goes low once ack_after high samples have been seen.
    task automatic run_command(t_kind kind, t_byte tx, logic sack, int ack_after,
                               int unsigned rej_pct);
        t_kind       k;
        logic        sda;
        int unsigned noise;
        push_tick(kind, tx, sack, 1'($urandom_range(0, 1)));
        while (plan_bus.phase != i2cmbe_pkg::PH_IDLE) begin
            if (plan_bus.phase == i2cmbe_pkg::PH_WA_POLL) begin
                sda = (plan_bus.polls >= ack_after) ? 1'b0 : 1'b1;
            end else begin
                sda = 1'($urandom_range(0, 1));
            end
            noise = $urandom_range(0, 99);
            if (noise < rej_pct) begin
                k = t_kind'($urandom_range(i2cmbe_pkg::K_START, i2cmbe_pkg::K_WAIT));
            end else if (noise < rej_pct + 3) begin
                k = t_kind'($urandom_range(KIND_SPARE_A, KIND_SPARE_B));
            end else begin
                k = i2cmbe_pkg::K_TICK;
            end
            push_tick(k, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    task automatic random_traffic(int unsigned count);
        int unsigned first;
        int          ack_after;
        t_kind       k;
        first = planned_items;
        while (planned_items - first < count) begin
            if ($urandom_range(0, 9) < 2) begin
                k = t_kind'($urandom_range(0, 2));
                if (k != i2cmbe_pkg::K_TICK) k = (k == 3'd1) ? KIND_SPARE_A : KIND_SPARE_B;
                push_tick(k, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 3) == 0) ack_after = NEVER_ACK;
                else ack_after = $urandom_range(0, ack_limit + 1);
                run_command(t_kind'($urandom_range(i2cmbe_pkg::K_START, i2cmbe_pkg::K_WAIT)),
                            t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            ack_after, 8);
            end
        end
    endtask

    task automatic settle();
        while (cmd_queue.size() != 0 || cmd_bus.valid || expected_pins.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [i2cmbe_pkg::CFG_IDX_W-1:0] idx,
                             logic [i2cmbe_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == i2cmbe_pkg::CFG_TICKS_PER_UNIT) unit_ticks = value;
        else ack_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Command side: a new item is offered only once the previous one has made its
    // transfer and its drawn gap has run out.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            send_wait = 0;
        end else if (!cmd_bus.valid || cmd_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                cmd_bus.valid <= 1'b0;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].drain && expected_pins.size() > 0)) begin
                item = cmd_queue.pop_front();
                cmd_bus.valid    <= 1'b1;
                cmd_bus.kind     <= item.kind;
                cmd_bus.tx_byte  <= item.tx_byte;
                cmd_bus.send_ack <= item.send_ack;
                cmd_bus.sda_in   <= item.sda_in;
                send_wait = draw_gap();
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (res_taken) begin
                if (hold_req) begin
                    recv_wait = LONG_HOLD;
                    hold_req  = 1'b0;
                end else begin
                    recv_wait = draw_gap();
                end
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            res_bus.ready <= (recv_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        i2cmbe_pkg::t_result got;
        i2cmbe_pkg::t_result want;
        cmd_taken <= i_rst_n && cmd_bus.valid && cmd_bus.ready;
        res_taken <= i_rst_n && res_bus.valid && res_bus.ready;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.scl          = res_bus.scl;
            got.sda_out      = res_bus.sda_out;
            got.sda_oe       = res_bus.sda_oe;
            got.busy_res     = res_bus.busy_res;
            got.done_res     = res_bus.done_res;
            got.rx_byte      = res_bus.rx_byte;
            got.ack_error    = res_bus.ack_error;
            got.cmd_rejected = res_bus.cmd_rejected;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result transfer: %s", format_pins(got));
                end
            end else begin
                want = expected_pins.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("pin mismatch: expected %s", format_pins(want));
                        $display("              actual   %s", format_pins(got));
                    end
                end
            end
        end
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            model_bus = tick_engine(model_bus, cmd_bus.kind, cmd_bus.tx_byte,
                                    cmd_bus.send_ack, cmd_bus.sda_in);
            expected_pins.push_back(pin_view(model_bus));
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = i2cmbe_pkg::CFG_TICKS_PER_UNIT;
        i_cfg_data       = '0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.kind     = i2cmbe_pkg::K_TICK;
        cmd_bus.tx_byte  = '0;
        cmd_bus.send_ack = 1'b0;
        cmd_bus.sda_in   = 1'b1;
        res_bus.ready    = 1'b0;
        plan_bus  = bus_at_reset();
        model_bus = bus_at_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle ticks, spare kinds, every command, refused commands,
        // an acknowledge timeout and the flag clearing on the next wait.
        push_tick(i2cmbe_pkg::K_TICK, 8'h00, 1'b0, 1'b0);
        push_tick(KIND_SPARE_A, 8'hFF, 1'b1, 1'b1);
        push_tick(KIND_SPARE_B, 8'h5A, 1'b0, 1'b1);
        run_command(i2cmbe_pkg::K_START, 8'h00, 1'b0, 0, 25);
        run_command(i2cmbe_pkg::K_WRITE, 8'hFF, 1'b0, 0, 0);
        run_command(i2cmbe_pkg::K_WRITE, 8'h00, 1'b1, 0, 10);
        run_command(i2cmbe_pkg::K_READ, 8'h00, 1'b1, 0, 0);
        run_command(i2cmbe_pkg::K_READ, 8'hFF, 1'b0, 0, 0);
        run_command(i2cmbe_pkg::K_WAIT, 8'h00, 1'b0, 0, 0);
        run_command(i2cmbe_pkg::K_WAIT, 8'h00, 1'b0, 5, 10);
        run_command(i2cmbe_pkg::K_WAIT, 8'h00, 1'b0, NEVER_ACK, 0);
        run_command(i2cmbe_pkg::K_WAIT, 8'h00, 1'b1, 1, 0);
        run_command(i2cmbe_pkg::K_STOP, 8'h00, 1'b0, 0, 0);
        settle();

        write_reg(i2cmbe_pkg::CFG_TICKS_PER_UNIT, 8'd0);
        write_reg(i2cmbe_pkg::CFG_ACK_TIMEOUT, 8'd0);
        idle_pct = 30;
        random_traffic(BATCH_ITEMS);
        settle();

        write_reg(i2cmbe_pkg::CFG_TICKS_PER_UNIT, 8'd2);
        write_reg(i2cmbe_pkg::CFG_ACK_TIMEOUT, 8'd3);
        idle_pct = 60;
        hold_req = 1'b1;
        random_traffic(BATCH_ITEMS);
        drain_next = 1'b1;
        random_traffic(BATCH_ITEMS);
        settle();

        write_reg(i2cmbe_pkg::CFG_TICKS_PER_UNIT, 8'd1);
        write_reg(i2cmbe_pkg::CFG_ACK_TIMEOUT, 8'd7);
        idle_pct = 20;
        random_traffic(BATCH_ITEMS);
        settle();

        if (mismatches == 0 && expected_pins.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
